// ===== design/pst_pkg.sv =====
// ----------------------------------------------------------------------------
// Parabolic SAR tracker package
// Item types, register codes, reset values and fixed widths.
// ----------------------------------------------------------------------------
`default_nettype none

package pst_pkg;

    localparam int PRICE_W = 32;
    localparam int TIME_W  = 32;
    localparam int MS_W    = 42;
    localparam int AF_W    = 16;
    localparam int WARM_W  = 7;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    // Number of bars that only seed the trend; the last of them also emits.
    localparam logic [WARM_W-1:0] WARMUP_BARS = 7'd5;
    localparam logic [WARM_W-1:0] EMIT_FROM   = WARMUP_BARS - 7'd1;

    localparam logic [MS_W-1:0] MS_PER_S = 42'd1000;

    localparam logic [AF_W-1:0] AF_STEP_RESET  = 16'd1311;
    localparam logic [AF_W-1:0] AF_LIMIT_RESET = 16'd13107;

    // Rounding constant for the Q32.16 product: one half.
    localparam logic [48:0] ROUND_HALF = 49'd32768;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_AF_STEP  = 8'd0,
        REG_AF_LIMIT = 8'd1
    } cfg_reg_t;

    typedef struct packed {
        logic [PRICE_W-1:0] bar_high;
        logic [PRICE_W-1:0] bar_low;
        logic [TIME_W-1:0]  bar_time;
    } bar_t;

    typedef struct packed {
        logic [PRICE_W-1:0] stop_value;
        logic               trend_long;
        logic [MS_W-1:0]    time_ms;
    } result_t;

endpackage

`default_nettype wire

// ===== design/pst_in_reg.sv =====
// ----------------------------------------------------------------------------
// Input register
// Holds one accepted bar until the core consumes it.
// ----------------------------------------------------------------------------
`default_nettype none

module pst_in_reg (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          bar_valid,
    input  wire pst_pkg::bar_t bar_item,
    input  wire logic          consume,
    output logic               bar_stall,
    output logic               held_valid,
    output pst_pkg::bar_t      held_bar
);

    logic          vld_reg;
    logic          vld_next;
    pst_pkg::bar_t bar_reg;
    logic          accept;

    // The register is free when empty or when its item leaves this cycle.
    assign bar_stall = vld_reg && !consume;
    assign accept    = bar_valid && !bar_stall;

    always_comb
    begin
        if (accept)
        begin
            vld_next = 1'b1;
        end
        else if (consume)
        begin
            vld_next = 1'b0;
        end
        else
        begin
            vld_next = vld_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            bar_reg <= bar_item;
        end
    end

    assign held_valid = vld_reg;
    assign held_bar   = bar_reg;

endmodule

`default_nettype wire

// ===== design/pst_core.sv =====
// ----------------------------------------------------------------------------
// SAR core
// Tracker state and the single-pass update of one bar.
// ----------------------------------------------------------------------------
`default_nettype none

module pst_core (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       fire,
    input  wire pst_pkg::bar_t              bar,
    input  wire logic [pst_pkg::AF_W-1:0]   af_step,
    input  wire logic [pst_pkg::AF_W-1:0]   af_limit,
    output logic                            emit,
    output pst_pkg::result_t                result
);

    logic [pst_pkg::PRICE_W-1:0] stop_reg,  stop_next;
    logic [pst_pkg::AF_W-1:0]    accel_reg, accel_next;
    logic [pst_pkg::PRICE_W-1:0] hx_reg,    hx_next;
    logic [pst_pkg::PRICE_W-1:0] lx_reg,    lx_next;
    logic                        long_reg,  long_next;
    logic [pst_pkg::PRICE_W-1:0] ph_reg;
    logic [pst_pkg::PRICE_W-1:0] pl_reg;
    logic [pst_pkg::WARM_W-1:0]  warm_reg,  warm_next;
    logic [pst_pkg::PRICE_W-1:0] smin_reg,  smin_next;
    logic [pst_pkg::PRICE_W-1:0] smax_reg,  smax_next;

    logic [pst_pkg::PRICE_W-1:0] hi;
    logic [pst_pkg::PRICE_W-1:0] lo;
    logic                        in_warm;

    // After seeding.
    logic [pst_pkg::PRICE_W-1:0] stop0, hx0, lx0;
    logic                        long0;
    // After the flip check.
    logic [pst_pkg::PRICE_W-1:0] stop1, hx1, lx1;
    logic [pst_pkg::AF_W-1:0]    acc1;
    logic                        long1;
    logic                        flip_dn;
    logic                        flip_up;
    // Stop update.
    logic [pst_pkg::PRICE_W-1:0] ep;
    logic                        move_up;
    logic [pst_pkg::PRICE_W-1:0] diff;
    logic [47:0]                 mag;
    logic [48:0]                 mag_rnd;
    logic [pst_pkg::PRICE_W-1:0] delta;
    logic [pst_pkg::PRICE_W:0]   up_sum;
    logic [pst_pkg::PRICE_W-1:0] stop2;
    logic [pst_pkg::AF_W:0]      acc_sum;
    logic                        grow;
    logic [pst_pkg::AF_W-1:0]    acc2;

    assign hi      = bar.bar_high;
    assign lo      = bar.bar_low;
    assign in_warm = warm_reg < pst_pkg::WARMUP_BARS;
    assign emit    = warm_reg >= pst_pkg::EMIT_FROM;

    // Seeding during warm-up.
    always_comb
    begin
        stop0     = stop_reg;
        long0     = long_reg;
        hx0       = hx_reg;
        lx0       = lx_reg;
        smin_next = smin_reg;
        smax_next = smax_reg;
        if (in_warm)
        begin
            if (warm_reg == '0)
            begin
                smin_next = lo;
                smax_next = hi;
                stop0     = lo;
                long0     = 1'b1;
                hx0       = hi;
                lx0       = lo;
            end
            else if (lo < smin_reg)
            begin
                smin_next = lo;
                stop0     = lo;
                long0     = 1'b1;
                hx0       = hi;
                lx0       = lo;
            end
            else if (hi > smax_reg)
            begin
                smax_next = hi;
                stop0     = hi;
                long0     = 1'b0;
                hx0       = hi;
                lx0       = lo;
            end
        end
    end

    // Trend flip against this bar and the previous one.
    assign flip_dn = long0 && (stop0 > lo || stop0 > pl_reg);
    assign flip_up = !long0 && (stop0 < hi || stop0 < ph_reg);

    always_comb
    begin
        stop1 = stop0;
        acc1  = accel_reg;
        long1 = long0;
        hx1   = hx0;
        lx1   = lx0;
        if (flip_dn || flip_up)
        begin
            stop1 = flip_dn ? hx0 : lx0;
            acc1  = af_step;
            long1 = flip_up;
            hx1   = (ph_reg > hi) ? ph_reg : hi;
            lx1   = (pl_reg < lo) ? pl_reg : lo;
        end
    end

    // Stop moves toward the extreme point; product rounded half away from zero.
    assign ep      = long1 ? hx1 : lx1;
    assign move_up = ep >= stop1;
    assign diff    = move_up ? (ep - stop1) : (stop1 - ep);
    assign mag     = {16'd0, diff} * {32'd0, acc1};
    assign mag_rnd = {1'b0, mag} + pst_pkg::ROUND_HALF;
    assign delta   = mag_rnd[47:16];
    assign up_sum  = {1'b0, stop1} + {1'b0, delta};

    always_comb
    begin
        if (move_up)
        begin
            stop2 = up_sum[pst_pkg::PRICE_W] ? '1 : up_sum[pst_pkg::PRICE_W-1:0];
        end
        else
        begin
            stop2 = (delta > stop1) ? '0 : (stop1 - delta);
        end
    end

    assign grow    = (acc1 < af_limit) &&
                     ((long1 && hx1 < hi) || (!long1 && lx1 > lo));
    assign acc_sum = {1'b0, acc1} + {1'b0, af_step};
    assign acc2    = !grow ? acc1 :
                     (acc_sum[pst_pkg::AF_W] ? '1 : acc_sum[pst_pkg::AF_W-1:0]);

    always_comb
    begin
        warm_next = in_warm ? (warm_reg + 7'd1) : warm_reg;
        if (emit)
        begin
            stop_next  = stop2;
            accel_next = acc2;
            long_next  = long1;
            hx_next    = (hx1 > hi) ? hx1 : hi;
            lx_next    = (lx1 < lo) ? lx1 : lo;
        end
        else
        begin
            stop_next  = stop0;
            accel_next = accel_reg;
            long_next  = long0;
            hx_next    = hx0;
            lx_next    = lx0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stop_reg  <= '0;
            accel_reg <= pst_pkg::AF_STEP_RESET;
            hx_reg    <= '0;
            lx_reg    <= '0;
            long_reg  <= 1'b1;
            ph_reg    <= '0;
            pl_reg    <= '0;
            warm_reg  <= '0;
            smin_reg  <= '0;
            smax_reg  <= '0;
        end
        else if (fire)
        begin
            stop_reg  <= stop_next;
            accel_reg <= accel_next;
            hx_reg    <= hx_next;
            lx_reg    <= lx_next;
            long_reg  <= long_next;
            ph_reg    <= hi;
            pl_reg    <= lo;
            warm_reg  <= warm_next;
            smin_reg  <= smin_next;
            smax_reg  <= smax_next;
        end
    end

    assign result.stop_value = stop1;
    assign result.trend_long = long1;
    assign result.time_ms    = {10'd0, bar.bar_time} * pst_pkg::MS_PER_S;

endmodule

`default_nettype wire

// ===== design/pst_out_reg.sv =====
// ----------------------------------------------------------------------------
// Result register
// Holds one result item until the downstream side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module pst_out_reg (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             load,
    input  wire pst_pkg::result_t result,
    input  wire logic             stop_stall,
    output logic                  free,
    output logic                  stop_valid,
    output pst_pkg::result_t      stop_item
);

    logic             vld_reg;
    logic             vld_next;
    pst_pkg::result_t res_reg;

    assign free = !vld_reg || !stop_stall;

    always_comb
    begin
        if (load)
        begin
            vld_next = 1'b1;
        end
        else if (!stop_stall)
        begin
            vld_next = 1'b0;
        end
        else
        begin
            vld_next = vld_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= result;
        end
    end

    assign stop_valid = vld_reg;
    assign stop_item  = res_reg;

endmodule

`default_nettype wire

// ===== design/parabolic_sar_tracker.sv =====
// ----------------------------------------------------------------------------
// Parabolic SAR tracker
// Wilder stop-and-reverse over a stream of price bars, one bar per cycle when not stalled.
// ----------------------------------------------------------------------------
// Path: a bar accepted into the input register is processed combinationally and its
// result is loaded into the result register; a stall in either register holds it.
// Throughput: one bar per cycle unless stalled; the state update (one 32x16
// multiply with its compares) is combinational between input and result registers.
// Reset: asynchronous, active low; clears state, restores register defaults,
// and no clearing pass is needed, so bars are taken right after release.
`default_nettype none

module parabolic_sar_tracker (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            bar_valid,
    output logic                                 bar_stall,
    input  wire pst_pkg::bar_t                   bar_item,
    output logic                                 stop_valid,
    input  wire logic                            stop_stall,
    output pst_pkg::result_t                     stop_item,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [pst_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [pst_pkg::CFG_DATA_W-1:0]  cfg_data
);

    logic [pst_pkg::AF_W-1:0] af_step_reg;
    logic [pst_pkg::AF_W-1:0] af_limit_reg;

    logic             held_valid;
    pst_pkg::bar_t    held_bar;
    logic             emit;
    logic             out_free;
    logic             fire;
    pst_pkg::result_t result;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            af_step_reg  <= pst_pkg::AF_STEP_RESET;
            af_limit_reg <= pst_pkg::AF_LIMIT_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                pst_pkg::REG_AF_STEP:  af_step_reg  <= cfg_data;
                pst_pkg::REG_AF_LIMIT: af_limit_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // A held bar that gives a result waits for room in the result register.
    assign fire = held_valid && (!emit || out_free);

    pst_in_reg u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .bar_valid  (bar_valid),
        .bar_item   (bar_item),
        .consume    (fire),
        .bar_stall  (bar_stall),
        .held_valid (held_valid),
        .held_bar   (held_bar)
    );

    pst_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (fire),
        .bar      (held_bar),
        .af_step  (af_step_reg),
        .af_limit (af_limit_reg),
        .emit     (emit),
        .result   (result)
    );

    pst_out_reg u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (fire && emit),
        .result     (result),
        .stop_stall (stop_stall),
        .free       (out_free),
        .stop_valid (stop_valid),
        .stop_item  (stop_item)
    );

endmodule

`default_nettype wire

// ===== design/pst_checker.sv =====
// ----------------------------------------------------------------------------
// SAR tracker port checker
// Watches the ports of the tracker for stalls, warm-up and time scaling.
// ----------------------------------------------------------------------------
`default_nettype none

module pst_port_assertions (
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             bar_valid,
    input wire logic             bar_stall,
    input wire logic             stop_valid,
    input wire logic             stop_stall,
    input wire pst_pkg::result_t stop_item
);

    logic [pst_pkg::WARM_W-1:0] seen_reg;

    // Bars accepted so far, saturating at the warm-up length.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= '0;
        end
        else if (bar_valid && !bar_stall && seen_reg < pst_pkg::WARMUP_BARS)
        begin
            seen_reg <= seen_reg + 7'd1;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        stop_valid && stop_stall |=> stop_valid && $stable(stop_item))
        else $error("result changed while stalled");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        bar_stall |-> stop_valid && stop_stall)
        else $error("input stalled while result side was free");

    a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
        stop_valid |-> seen_reg >= pst_pkg::WARMUP_BARS)
        else $error("result before warm-up finished");

    a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
        stop_valid |-> stop_item.time_ms < 42'd4294967295001)
        else $error("time scaling out of range");

endmodule

bind parabolic_sar_tracker pst_port_assertions u_pst_assert (
    .clk        (clk),
    .rst_n      (rst_n),
    .bar_valid  (bar_valid),
    .bar_stall  (bar_stall),
    .stop_valid (stop_valid),
    .stop_stall (stop_stall),
    .stop_item  (stop_item)
);

`default_nettype wire
